// ----- sv/zft_pkg.sv -----
// ----------------------------------------------------------------------------
// zft_pkg
// Shared constants and types for the zone file tokenizer: character codes,
// default token limit and the result record carried through the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

package zft_pkg;

    // character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // default limit on kept tokens per record
    localparam int MAX_TOKENS_DEF = 64;

    // field index width
    localparam int FIELD_W = 6;

    // output queue depth (two results may be pushed per request)
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // one result item
    typedef struct packed {
        logic               data_valid;
        logic [7:0]         out_byte;
        logic [FIELD_W-1:0] field_index;
        logic               token_first;
        logic               token_last;
        logic               record_end;
        logic               owner_blank;
        logic               run_last;
    } res_t;

endpackage

`default_nettype wire

// ----- sv/zone_file_tokenizer_unit.sv -----
// ----------------------------------------------------------------------------
// zone_file_tokenizer_unit
// Splits zone file text into tokens and records, one byte per clock when the
// queue has room, handling comments, parentheses, quoting and escapes.
// ----------------------------------------------------------------------------
// One text byte is taken per clock while at least two result queue entries
// are free. Each byte is scanned in a single pass of flag logic and yields
// zero, one or two result items, which go into a four-entry result queue;
// when results are produced faster than the result side takes them, the
// queue fills and input bytes are held off until it drains. Tokens beyond
// MAX_TOKENS in a record are scanned but dropped. s_tlast closes the buffer:
// any open token and non-empty record are ended and the tokenizer returns
// to its reset state.
// ----------------------------------------------------------------------------
`default_nettype none

module zone_file_tokenizer_unit #(
    parameter int MAX_TOKENS = zft_pkg::MAX_TOKENS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input text
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,   // in_last
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] out_byte, [13:8] field_index, [14] token_first, [15] token_last,
    // [16] record_end, [17] owner_blank, [23:18] zero
    output logic [23:0]      m_tdata,
    output logic             m_tuser,   // data_valid
    output logic             m_tlast    // run_last
);

    localparam int CNT_W = $clog2(MAX_TOKENS + 1);
    localparam int EXT_W = CNT_W + zft_pkg::FIELD_W;
    localparam int QD    = zft_pkg::QDEPTH;
    localparam int QW    = zft_pkg::QPTR_W;

    // scanner state
    logic             at_line_start_reg, at_line_start_next;
    logic             paren_open_reg, paren_open_next;
    logic             quote_open_reg, quote_open_next;
    logic             comment_skip_reg, comment_skip_next;
    logic             token_active_reg, token_active_next;
    logic             escape_pending_reg, escape_pending_next;
    logic             began_quoted_reg, began_quoted_next;
    logic             no_content_reg, no_content_next;
    logic             hold_valid_reg, hold_valid_next;
    logic [7:0]       hold_byte_reg, hold_byte_next;
    logic [CNT_W-1:0] token_count_reg, token_count_next;
    logic             owner_blank_reg, owner_blank_next;
    logic             tok_kept_reg, tok_kept_next;

    // results of this byte
    zft_pkg::res_t    res_next [2];
    logic [1:0]       res_cnt;

    // result queue
    zft_pkg::res_t    q_mem [QD];
    logic [QW-1:0]    q_wr_reg, q_rd_reg;
    logic [QW:0]      q_cnt_reg;

    logic             in_acc, out_acc;
    logic [QW:0]      push_cnt;

    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign s_tready = q_cnt_reg <= (QW + 1)'(QD - 2);

    // single pass over the incoming byte
    always_comb begin
        logic [7:0]       c;
        logic             blank, nl, delim_c;
        logic             tok_byte, is_first, do_content, do_end, do_delim;
        logic             emit_v, rec_req;
        logic [EXT_W-1:0] idx_ext;
        logic [zft_pkg::FIELD_W-1:0] idx;
        zft_pkg::res_t    e;

        c       = s_tdata;
        blank   = (c == zft_pkg::CH_SPACE) || (c == zft_pkg::CH_TAB);
        nl      = (c == zft_pkg::CH_LF) || (c == zft_pkg::CH_CR);
        delim_c = blank || nl || (c == zft_pkg::CH_SEMI) ||
                  (c == zft_pkg::CH_LPAREN) || (c == zft_pkg::CH_RPAREN);

        at_line_start_next  = at_line_start_reg;
        paren_open_next     = paren_open_reg;
        quote_open_next     = quote_open_reg;
        comment_skip_next   = comment_skip_reg;
        token_active_next   = token_active_reg;
        escape_pending_next = escape_pending_reg;
        began_quoted_next   = began_quoted_reg;
        no_content_next     = no_content_reg;
        hold_valid_next     = hold_valid_reg;
        hold_byte_next      = hold_byte_reg;
        token_count_next    = token_count_reg;
        owner_blank_next    = owner_blank_reg;
        tok_kept_next       = tok_kept_reg;

        res_next[0] = '0;
        res_next[1] = '0;
        res_cnt     = 2'd0;
        tok_byte    = 1'b0;
        is_first    = 1'b0;
        do_content  = 1'b0;
        do_end      = 1'b0;
        do_delim    = 1'b0;
        emit_v      = 1'b0;
        rec_req     = 1'b0;
        e           = '0;

        // line start: reset quoting, note inherited owner
        if (at_line_start_reg) begin
            at_line_start_next = 1'b0;
            quote_open_next    = 1'b0;
            owner_blank_next   = blank;
            token_count_next   = blank ? CNT_W'(1) : '0;
        end

        // choose the path for this byte
        if (comment_skip_reg) begin
            if (c == zft_pkg::CH_LF) begin
                comment_skip_next = 1'b0;
                do_delim          = 1'b1;
            end
        end else if (token_active_reg) begin
            tok_byte = 1'b1;
        end else if (delim_c) begin
            do_delim = 1'b1;
        end else begin
            token_active_next = 1'b1;
            no_content_next   = 1'b1;
            hold_valid_next   = 1'b0;
            began_quoted_next = (c == zft_pkg::CH_QUOTE);
            tok_kept_next     = token_count_next < CNT_W'(MAX_TOKENS);
            if (tok_kept_next) begin
                token_count_next = token_count_next + CNT_W'(1);
            end
            tok_byte = 1'b1;
            is_first = 1'b1;
        end

        // byte inside a token
        if (tok_byte) begin
            if (escape_pending_next) begin
                escape_pending_next = 1'b0;
                do_content          = 1'b1;
            end else if (c == zft_pkg::CH_BSLASH) begin
                escape_pending_next = 1'b1;
                do_content          = 1'b1;
            end else if (c == zft_pkg::CH_QUOTE) begin
                quote_open_next = !quote_open_next;
                do_content      = !is_first;
            end else if (quote_open_next ? nl : delim_c) begin
                do_end   = 1'b1;
                do_delim = 1'b1;
            end else begin
                do_content = 1'b1;
            end
        end

        // field index of the current token
        idx_ext = EXT_W'(token_count_next) - EXT_W'(1);
        idx     = (token_count_next == '0) ? '0 : idx_ext[zft_pkg::FIELD_W-1:0];

        // content byte: release the held byte, hold the new one
        if (do_content && tok_kept_next) begin
            if (hold_valid_next) begin
                e             = '0;
                e.data_valid  = 1'b1;
                e.out_byte    = hold_byte_next;
                e.field_index = idx;
                e.token_first = no_content_next;
                e.owner_blank = owner_blank_next;
                res_next[res_cnt[0]] = e;
                res_cnt         = res_cnt + 2'd1;
                no_content_next = 1'b0;
            end
            hold_byte_next  = c;
            hold_valid_next = 1'b1;
        end

        // token end from a delimiter
        if (do_end) begin
            if (tok_kept_next) begin
                emit_v        = hold_valid_next && !(began_quoted_next &&
                                hold_byte_next == zft_pkg::CH_QUOTE);
                e             = '0;
                e.data_valid  = emit_v;
                e.out_byte    = emit_v ? hold_byte_next : 8'd0;
                e.field_index = idx;
                e.token_first = no_content_next;
                e.token_last  = 1'b1;
                e.owner_blank = owner_blank_next;
                res_next[res_cnt[0]] = e;
                res_cnt = res_cnt + 2'd1;
            end
            token_active_next   = 1'b0;
            escape_pending_next = 1'b0;
            began_quoted_next   = 1'b0;
            no_content_next     = 1'b1;
            hold_valid_next     = 1'b0;
            hold_byte_next      = 8'd0;
            tok_kept_next       = 1'b0;
        end

        // delimiter effects
        if (do_delim) begin
            if (nl) begin
                if (!paren_open_next) begin
                    rec_req            = 1'b1;
                    at_line_start_next = 1'b1;
                end
            end else if (c == zft_pkg::CH_SEMI) begin
                comment_skip_next = 1'b1;
            end else if (c == zft_pkg::CH_LPAREN) begin
                paren_open_next = 1'b1;
            end else if (c == zft_pkg::CH_RPAREN) begin
                paren_open_next = 1'b0;
            end
        end

        // end of buffer closes an open token
        if (s_tlast && token_active_next) begin
            if (tok_kept_next) begin
                emit_v        = hold_valid_next && !(began_quoted_next &&
                                hold_byte_next == zft_pkg::CH_QUOTE);
                e             = '0;
                e.data_valid  = emit_v;
                e.out_byte    = emit_v ? hold_byte_next : 8'd0;
                e.field_index = idx;
                e.token_first = no_content_next;
                e.token_last  = 1'b1;
                e.owner_blank = owner_blank_next;
                res_next[res_cnt[0]] = e;
                res_cnt = res_cnt + 2'd1;
            end
        end

        // record end: merged onto the last result, else sent alone
        if ((rec_req || s_tlast) && token_count_next != '0) begin
            if (res_cnt == 2'd0) begin
                e             = '0;
                e.owner_blank = owner_blank_next;
                res_next[0]   = e;
                res_cnt       = 2'd1;
            end
            res_next[res_cnt[1]].record_end = 1'b1;
            token_count_next = '0;
        end

        // mark the last result of this byte
        if (res_cnt != 2'd0) begin
            res_next[res_cnt[1]].run_last = 1'b1;
        end

        // end of buffer returns everything to reset
        if (s_tlast) begin
            at_line_start_next  = 1'b1;
            paren_open_next     = 1'b0;
            quote_open_next     = 1'b0;
            comment_skip_next   = 1'b0;
            token_active_next   = 1'b0;
            escape_pending_next = 1'b0;
            began_quoted_next   = 1'b0;
            no_content_next     = 1'b1;
            hold_valid_next     = 1'b0;
            hold_byte_next      = 8'd0;
            token_count_next    = '0;
            owner_blank_next    = 1'b0;
            tok_kept_next       = 1'b0;
        end
    end

    // scanner state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_line_start_reg  <= 1'b1;
            paren_open_reg     <= 1'b0;
            quote_open_reg     <= 1'b0;
            comment_skip_reg   <= 1'b0;
            token_active_reg   <= 1'b0;
            escape_pending_reg <= 1'b0;
            began_quoted_reg   <= 1'b0;
            no_content_reg     <= 1'b1;
            hold_valid_reg     <= 1'b0;
            token_count_reg    <= '0;
            owner_blank_reg    <= 1'b0;
            tok_kept_reg       <= 1'b0;
        end else if (in_acc) begin
            at_line_start_reg  <= at_line_start_next;
            paren_open_reg     <= paren_open_next;
            quote_open_reg     <= quote_open_next;
            comment_skip_reg   <= comment_skip_next;
            token_active_reg   <= token_active_next;
            escape_pending_reg <= escape_pending_next;
            began_quoted_reg   <= began_quoted_next;
            no_content_reg     <= no_content_next;
            hold_valid_reg     <= hold_valid_next;
            token_count_reg    <= token_count_next;
            owner_blank_reg    <= owner_blank_next;
            tok_kept_reg       <= tok_kept_next;
        end
    end

    // held byte needs no reset
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            hold_byte_reg <= hold_byte_next;
        end
    end

    // result queue storage
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            if (res_cnt != 2'd0) begin
                q_mem[q_wr_reg] <= res_next[0];
            end
            if (res_cnt == 2'd2) begin
                q_mem[q_wr_reg + QW'(1)] <= res_next[1];
            end
        end
    end

    assign push_cnt = in_acc ? (QW + 1)'(res_cnt) : '0;

    // result queue pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end else begin
            q_wr_reg  <= q_wr_reg + push_cnt[QW-1:0];
            q_rd_reg  <= q_rd_reg + QW'(out_acc);
            q_cnt_reg <= q_cnt_reg + push_cnt - (QW + 1)'(out_acc);
        end
    end

    // output port
    assign m_tvalid = q_cnt_reg != '0;
    assign m_tuser  = q_mem[q_rd_reg].data_valid;
    assign m_tlast  = q_mem[q_rd_reg].run_last;
    assign m_tdata  = {6'd0,
                       q_mem[q_rd_reg].owner_blank,
                       q_mem[q_rd_reg].record_end,
                       q_mem[q_rd_reg].token_last,
                       q_mem[q_rd_reg].token_first,
                       q_mem[q_rd_reg].field_index,
                       q_mem[q_rd_reg].out_byte};

    // queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt_reg <= (QW + 1)'(QD))
        else $error("result queue overflow");

    // a comment and a token are never open together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(comment_skip_reg && token_active_reg))
        else $error("comment and token open together");

    // a held byte belongs to an open, kept token
    assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> (token_active_reg && tok_kept_reg))
        else $error("held byte outside a kept token");

    // token count saturates at the limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        token_count_reg <= CNT_W'(MAX_TOKENS))
        else $error("token count beyond limit");

    // end of buffer leaves the scanner at a clean line start
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_tlast) |=> (at_line_start_reg && !token_active_reg &&
                                 token_count_reg == '0 && !paren_open_reg))
        else $error("state not cleared after end of buffer");

endmodule

`default_nettype wire
